// ----- src/fixed_block_pool_allocator_unit_assert.svh -----
// ============================================================================
// Assertion macros for the fixed block pool allocator
// Immediate-cycle and next-cycle property forms, clocked on clk and
// disabled while rst_n is low.
// ============================================================================
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FBPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fbpa_pkg.sv -----
// ============================================================================
// fbpa_pkg
// Shared constants, codes and item types of the block pool allocator.
// ============================================================================
package fbpa_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int ADDR_W     = 32;

  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int RAW_W      = 16;
  localparam int ALIGN_W    = 13;
  localparam int ENTRY_W    = 11;
  localparam int SIZE_W     = RAW_W + 1;
  localparam int PROD_W     = IDX_W + SIZE_W;
  localparam int CFG_W      = ADDR_W;
  localparam int CFG_IDX_W  = 2;

  // depth of the command queue and of the result queue
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_REINIT = 2'd2,
    REQ_XLATE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NONE_ALLOC = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_SIZE = 2'd0,
    CFG_ALIGN    = 2'd1,
    CFG_ENTRIES  = 2'd2,
    CFG_BASE     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    req_t              req_type;
    logic [ADDR_W-1:0] block_address;
    logic [IDX_W-1:0]  block_number;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  result_index;
    logic [ADDR_W-1:0] result_address;
    logic              pool_full;
    logic [CNT_W-1:0]  allocated_now;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    req_t              op;
    logic [ADDR_W-1:0] offset;
    logic [IDX_W-1:0]  block_number;
    logic              bnum_oor;
  } cmd_t;

  // pool geometry derived from the configuration registers
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  n_eff;
    logic [ADDR_W-1:0] base;
  } pool_cfg_t;

endpackage

// ----- src/fbpa_ram.sv -----
// ============================================================================
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fbpa_div.sv -----
// ============================================================================
// fbpa_div
// Restoring divider, one quotient bit per cycle, ADDR_W steps per divide.
// ============================================================================
module fbpa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [fbpa_pkg::ADDR_W-1:0] quotient
);
  import fbpa_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;     // dividend shifts out, quotient shifts in
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dsr_r, dsr_nxt;
  logic [SIZE_W:0]   trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[ADDR_W-1]};
    ge       = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(ADDR_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? SIZE_W'(trial - {1'b0, dsr_r}) : SIZE_W'(trial);
      quo_nxt  = {quo_r[ADDR_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/fbpa_front.sv -----
// ============================================================================
// fbpa_front
// Configuration registers, request classification and command queue.
// ============================================================================
module fbpa_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  fbpa_pkg::in_item_t             in_data,
  input  logic                           cmd_pop,
  output logic                           cmd_valid,
  output fbpa_pkg::cmd_t                 cmd_data,
  output fbpa_pkg::pool_cfg_t            pool_cfg
);
  import fbpa_pkg::*;

  localparam int RAW_RST   = 16;
  localparam int ALIGN_RST = 4;
  localparam int ENTRY_RST = 1024;

  // size = ((a - raw) & (a - 1)) + raw, alignment zero taken as one
  function automatic logic [SIZE_W-1:0] calc_size(input logic [RAW_W-1:0]   raw,
                                                  input logic [ALIGN_W-1:0] align);
    logic [ALIGN_W-1:0] a;
    logic [ALIGN_W-1:0] pad;
    a   = (align == '0) ? ALIGN_W'(1) : align;
    pad = (a - raw[ALIGN_W-1:0]) & (a - ALIGN_W'(1));
    return SIZE_W'(pad) + SIZE_W'(raw);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_entries(input logic [ENTRY_W-1:0] e);
    return (32'(e) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(e);
  endfunction

  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic [ALIGN_W-1:0] align_r, align_nxt;
  logic [ENTRY_W-1:0] entries_r, entries_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [SIZE_W-1:0]  size_r;
  logic [CNT_W-1:0]   n_eff_r;

  always_comb begin
    raw_nxt     = raw_r;
    align_nxt   = align_r;
    entries_nxt = entries_r;
    base_nxt    = base_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RAW_SIZE: raw_nxt     = cfg_wdata[RAW_W-1:0];
        CFG_ALIGN:    align_nxt   = cfg_wdata[ALIGN_W-1:0];
        CFG_ENTRIES:  entries_nxt = cfg_wdata[ENTRY_W-1:0];
        CFG_BASE:     base_nxt    = cfg_wdata[ADDR_W-1:0];
        default:      raw_nxt     = raw_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r     <= RAW_W'(RAW_RST);
      align_r   <= ALIGN_W'(ALIGN_RST);
      entries_r <= ENTRY_W'(ENTRY_RST);
      base_r    <= '0;
      size_r    <= calc_size(RAW_W'(RAW_RST), ALIGN_W'(ALIGN_RST));
      n_eff_r   <= clamp_entries(ENTRY_W'(ENTRY_RST));
    end else begin
      raw_r     <= raw_nxt;
      align_r   <= align_nxt;
      entries_r <= entries_nxt;
      base_r    <= base_nxt;
      size_r    <= calc_size(raw_nxt, align_nxt);
      n_eff_r   <= clamp_entries(entries_nxt);
    end
  end

  assign pool_cfg.size  = size_r;
  assign pool_cfg.n_eff = n_eff_r;
  assign pool_cfg.base  = base_r;

  // classify on the way in: byte offset and translate range check
  cmd_t cmd_in;
  always_comb begin
    cmd_in.op           = in_data.req_type;
    cmd_in.offset       = in_data.block_address - base_r;
    cmd_in.block_number = in_data.block_number;
    cmd_in.bnum_oor     = (CNT_W'(in_data.block_number) >= n_eff_r);
  end

  // command queue
  cmd_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push, pop;

  assign in_full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_data  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- src/fbpa_back.sv -----
// ============================================================================
// fbpa_back
// Executes commands: free-index stack, count, divider, address math,
// result queue.
// ============================================================================
module fbpa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fbpa_pkg::pool_cfg_t pool_cfg,
  input  logic                cmd_valid,
  input  fbpa_pkg::cmd_t      cmd_data,
  output logic                cmd_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output fbpa_pkg::out_item_t out_data
);
  import fbpa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ADD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   ac_r, ac_nxt;       // allocated count
  logic [CNT_W-1:0]   peak_r, peak_nxt;   // slots from ac_r up to this were written since refill
  status_t            status_r, status_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [CNT_W-1:0]   ac_dec;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_rdata;
  logic               div_start, div_done;
  logic [ADDR_W-1:0]  div_quo;

  // result queue
  out_item_t          rq_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] rq_wr_r, rq_rd_r;
  logic [Q_CNT_W-1:0] rq_cnt_r;
  logic               rq_push, rq_pop, rq_full;
  out_item_t          res_item;

  assign ac_dec    = ac_r - 1'b1;
  assign ram_waddr = ac_dec[IDX_W-1:0];

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (div_quo[IDX_W-1:0]),
    .raddr (ac_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cmd_data.offset),
    .divisor  (pool_cfg.size),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt  = state_r;
    ac_nxt     = ac_r;
    peak_nxt   = peak_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    addr_nxt   = addr_r;
    prod_nxt   = prod_r;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    rq_push    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          status_nxt = ST_OK;
          idx_nxt    = '0;
          addr_nxt   = '0;
          state_nxt  = S_DONE;
          case (cmd_data.op)
            REQ_ALLOC: begin
              if (ac_r >= pool_cfg.n_eff) begin
                status_nxt = ST_EXHAUSTED;
              end else begin
                state_nxt = S_READ;   // stack slot at ac_r is being read
              end
            end
            REQ_FREE: begin
              if (ac_r == '0) begin
                status_nxt = ST_NONE_ALLOC;
              end else if (pool_cfg.size == '0) begin
                status_nxt = ST_RANGE;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            REQ_REINIT: begin
              ac_nxt   = '0;
              peak_nxt = '0;
            end
            REQ_XLATE: begin
              if (cmd_data.bnum_oor) begin
                status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = cmd_data.block_number;
                state_nxt = S_MUL;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_READ: begin
        // never-written slots still hold the identity
        idx_nxt = (ac_r < peak_r) ? ram_rdata : ac_r[IDX_W-1:0];
        ac_nxt  = ac_r + 1'b1;
        if (ac_r >= peak_r) begin
          peak_nxt = ac_r + 1'b1;
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(idx_r) * PROD_W'(pool_cfg.size);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        addr_nxt  = pool_cfg.base + ADDR_W'(prod_r);
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quo >= ADDR_W'(pool_cfg.n_eff)) begin
            status_nxt = ST_RANGE;
          end else begin
            ac_nxt  = ac_dec;
            ram_we  = 1'b1;
            idx_nxt = div_quo[IDX_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!rq_full) begin
          rq_push   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ac_r    <= '0;
      peak_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ac_r    <= ac_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    addr_r   <= addr_nxt;
    prod_r   <= prod_nxt;
  end

  always_comb begin
    res_item.status         = status_r;
    res_item.result_index   = idx_r;
    res_item.result_address = addr_r;
    res_item.pool_full      = (ac_r >= pool_cfg.n_eff);
    res_item.allocated_now  = ac_r;
  end

  assign rq_full   = (rq_cnt_r == Q_CNT_W'(Q_DEPTH));
  assign out_empty = (rq_cnt_r == '0);
  assign rq_pop    = out_pop && !out_empty;
  assign out_data  = rq_r[rq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (rq_push) begin
        rq_wr_r <= (rq_wr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= (rq_rd_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rq_rd_r + 1'b1;
      end
      if (rq_push && !rq_pop) begin
        rq_cnt_r <= rq_cnt_r + 1'b1;
      end else if (rq_pop && !rq_push) begin
        rq_cnt_r <= rq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wr_r] <= res_item;
    end
  end

endmodule

// ----- src/fixed_block_pool_allocator_unit.sv -----
// ============================================================================
// fixed_block_pool_allocator_unit: fixed-size block pool, free-index stack
// One item executes at a time: free divides serially; allocate and translate multiply, then add
// Reset (rst_n low, synchronous): defaults, count zero, stack reads as identity at once
// ============================================================================
module fixed_block_pool_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_W-1:0]     cfg_wdata,
  // request queue side
  input  logic                           in_push,
  output logic                           in_full,
  input  fbpa_pkg::in_item_t             in_data,
  // result queue side
  output logic                           out_empty,
  input  logic                           out_pop,
  output fbpa_pkg::out_item_t            out_data
);
  import fbpa_pkg::*;

  // Front: holds the config registers and the derived pool geometry
  // (aligned block size, clamped entry count), computes the byte offset
  // of a free and the range flag of a translate, and queues the item.
  // Two-deep queues sit on both sides.
  //
  // Back: a one-hot sequencer owning the allocated count and the stack
  // RAM. Allocate reads the slot at the count; a slot at or above the
  // high-water mark has not been written since the last refill and
  // reads as its own index, so no clearing pass is needed. Free runs the
  // divider and pushes the quotient. Address = base + index * size,
  // registered between the multiply and the add. Results go to a small
  // queue so the back can finish while the consumer stalls.

  cmd_t      cmd_data;
  logic      cmd_valid;
  logic      cmd_pop;
  pool_cfg_t pool_cfg;

  fbpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .pool_cfg  (pool_cfg)
  );

  fbpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pool_cfg  (pool_cfg),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ----- src/fbpa_checker.sv -----
// ============================================================================
// fbpa_checker
// Port-level checks on result items, bound to the allocator top level.
// ============================================================================
`include "fixed_block_pool_allocator_unit_assert.svh"

module fbpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input fbpa_pkg::out_item_t out_data
);
  import fbpa_pkg::*;

  `FBPA_ASSERT_NOW(a_count_bound, !out_empty, out_data.allocated_now <= CNT_W'(MAX_BLOCKS), "allocated count above pool capacity")
  `FBPA_ASSERT_NOW(a_exhaust_full, !out_empty && out_data.status == ST_EXHAUSTED, out_data.pool_full, "exhausted item without full pool")
  `FBPA_ASSERT_NOW(a_err_clear, !out_empty && out_data.status != ST_OK, out_data.result_index == '0 && out_data.result_address == '0, "error item carries index or address")
  `FBPA_ASSERT_NOW(a_none_alloc, !out_empty && out_data.status == ST_NONE_ALLOC, out_data.allocated_now == '0, "empty-pool free with nonzero count")
  `FBPA_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_data), "stalled result item changed")

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);

// ----- tb/tb_fixed_block_pool_allocator_unit.sv -----
// ============================================================================
// Block pool allocator testbench
// Drives allocate, free, reinitialize and translate requests through the
// request queue under a series of pool geometries. A tracker keeps its own
// free-index stack, computes every expected result and compares them in
// order with what the result queue delivers.
// ============================================================================
module tb_fixed_block_pool_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Own model of the pool: free-index stack, count and registers.
  class pool_tracker;
    logic [IDX_W-1:0]  slots [MAX_BLOCKS];
    int unsigned       used;
    int unsigned       raw_size;
    int unsigned       align;
    int unsigned       entries;
    logic [ADDR_W-1:0] base;
    out_item_t         awaited [$];
    int unsigned       errors;

    function new();
      raw_size = 16;
      align    = 4;
      entries  = 1024;
      base     = '0;
      errors   = 0;
      refill();
    endfunction

    function void refill();
      for (int i = 0; i < MAX_BLOCKS; i++) slots[i] = IDX_W'(i);
      used = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_RAW_SIZE: raw_size = val[RAW_W-1:0];
        CFG_ALIGN:    align    = val[ALIGN_W-1:0];
        CFG_ENTRIES:  entries  = val[ENTRY_W-1:0];
        CFG_BASE:     base     = val[ADDR_W-1:0];
        default:      ;
      endcase
    endfunction

    // raw size rounded up to the alignment when that is a power of two; zero alignment means none
    function int unsigned block_bytes();
      int unsigned a;
      a = (align == 0) ? 1 : align;
      return ((a - raw_size) & (a - 1)) + raw_size;
    endfunction

    function int unsigned live_entries();
      return (entries > MAX_BLOCKS) ? MAX_BLOCKS : entries;
    endfunction

    function logic [ADDR_W-1:0] addr_of(int unsigned idx);
      logic [63:0] sum;
      sum = {32'b0, base} + 64'(idx) * 64'(block_bytes());
      return sum[ADDR_W-1:0];
    endfunction

    // works out the result of one accepted request and queues it
    function void apply_request(in_item_t rq);
      out_item_t         want;
      int unsigned       n;
      int unsigned       sz;
      logic [ADDR_W-1:0] off;
      longint unsigned   q;
      n    = live_entries();
      sz   = block_bytes();
      want = '0;
      case (rq.req_type)
        REQ_ALLOC: begin
          if (used >= n) begin
            want.status = ST_EXHAUSTED;
          end else begin
            want.result_index   = slots[used];
            used++;
            want.result_address = addr_of(want.result_index);
          end
        end
        REQ_FREE: begin
          if (used == 0) begin
            want.status = ST_NONE_ALLOC;
          end else begin
            off = rq.block_address - base;
            q   = (sz == 0) ? n : off / sz;
            if (q >= n) begin
              want.status = ST_RANGE;
            end else begin
              used--;
              slots[used]       = IDX_W'(q);
              want.result_index = IDX_W'(q);
            end
          end
        end
        REQ_REINIT: refill();
        REQ_XLATE: begin
          if (rq.block_number >= n) begin
            want.status = ST_RANGE;
          end else begin
            want.result_index   = rq.block_number;
            want.result_address = addr_of(rq.block_number);
          end
        end
        default: ;
      endcase
      want.pool_full     = (used >= n);
      want.allocated_now = CNT_W'(used);
      awaited.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("result item arrived with no request pending");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.result_index !== want.result_index) begin
        $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
        errors++;
      end
      if (got.result_address !== want.result_address) begin
        $error("result_address: expected %h, got %h", want.result_address,
               got.result_address);
        errors++;
      end
      if (got.pool_full !== want.pool_full) begin
        $error("pool_full: expected %0d, got %0d", want.pool_full, got.pool_full);
        errors++;
      end
      if (got.allocated_now !== want.allocated_now) begin
        $error("allocated_now: expected %0d, got %0d", want.allocated_now,
               got.allocated_now);
        errors++;
      end
    endfunction
  endclass

  // DUT signals; every input known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  in_item_t             in_data   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_item_t            out_data;

  pool_tracker chk = new();

  // stimulus mix knobs, set per phase
  int unsigned alloc_pct     = 45;
  bit          sender_steady = 1'b0;
  int unsigned cycle_cnt     = 0;

  fixed_block_pool_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned gap_len(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic in_item_t mk(req_t op, logic [ADDR_W-1:0] addr,
                                  logic [IDX_W-1:0] bnum);
    in_item_t rq;
    rq.req_type      = op;
    rq.block_address = addr;
    rq.block_number  = bnum;
    return rq;
  endfunction

  // Random request. Frees mostly target a block that is allocated right now
  // (any byte inside it), translates mostly stay in range; the rest is noise
  // with fully random fields.
  function automatic in_item_t next_request();
    in_item_t    rq;
    int unsigned pick;
    int unsigned n;
    int unsigned sz;
    int unsigned pos;
    rq   = mk(REQ_ALLOC, $urandom(), IDX_W'($urandom()));
    n    = chk.live_entries();
    sz   = chk.block_bytes();
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      rq.req_type = REQ_ALLOC;
    end else if (pick < 80) begin
      if (chk.used != 0) begin
        pos              = $urandom_range(0, chk.used - 1);
        rq.req_type      = REQ_FREE;
        rq.block_address = chk.addr_of(chk.slots[pos])
                           + ((sz == 0) ? 0 : $urandom_range(0, sz - 1));
      end
    end else if (pick < 90) begin
      rq.req_type = REQ_XLATE;
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        rq.block_number = IDX_W'($urandom_range(0, n - 1));
      end
    end else if (pick < 93) begin
      rq.req_type = REQ_REINIT;
    end else begin
      rq.req_type = req_t'($urandom_range(0, 3));
    end
    return rq;
  endfunction

  // Offer one item until the queue takes it, then idle a while. push stays
  // high into the next item when there is no gap.
  task automatic send_paced(in_item_t rq, bit last);
    int unsigned g;
    in_data <= rq;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    chk.apply_request(rq);
    g = last ? 0 : gap_len(sender_steady);
    if (last || g > 0) in_push <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned count, int unsigned tail_allocs);
    in_item_t rq;
    alloc_pct     = $urandom_range(30, 55);
    sender_steady = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < count + tail_allocs; k++) begin
      rq = next_request();
      if (k >= count) rq.req_type = REQ_ALLOC;
      send_paced(rq, k + 1 == count + tail_allocs);
    end
  endtask

  // every item gives one result, so an empty expectation queue means idle
  task automatic settle(int unsigned extra);
    while (chk.awaited.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    chk.set_reg(idx, val);
  endtask

  // new geometry, written only once the block has drained
  task automatic load_pool(int unsigned raw, int unsigned aln, int unsigned ents,
                           logic [ADDR_W-1:0] bas);
    settle(4);
    put_reg(CFG_RAW_SIZE, raw);
    put_reg(CFG_ALIGN, aln);
    put_reg(CFG_ENTRIES, ents);
    put_reg(CFG_BASE, bas);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random pops, with stretches of steady popping, and two long
  // hold-offs so the block backs up and raises in_full.
  initial begin
    int unsigned g;
    int unsigned taken;
    bit          steady;
    taken  = 0;
    steady = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      g = gap_len(steady);
      if (g > 0) begin
        out_pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      chk.check_result(out_data);
      taken++;
      if ($urandom_range(0, 49) == 0) steady = !steady;
      if (taken == 250 || taken == 900) begin
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("fixed_block_pool_allocator_unit test failed");
    $finish;
  end

  initial begin
    in_item_t plan [$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: 16-byte blocks, 1024 entries, base 0.
    plan.push_back(mk(REQ_FREE, 32'h0, '0));          // nothing allocated yet
    plan.push_back(mk(REQ_XLATE, 32'h0, '0));
    plan.push_back(mk(REQ_XLATE, 32'h0, '1));         // last block
    plan.push_back(mk(REQ_ALLOC, 32'h0, '0));
    plan.push_back(mk(REQ_ALLOC, 32'h0, '0));
    plan.push_back(mk(REQ_ALLOC, 32'h0, '0));
    plan.push_back(mk(REQ_FREE, 32'h13, '0));         // inside block 1, truncates
    plan.push_back(mk(REQ_FREE, 32'hFFFF_FFFF, '0));  // far out of range
    plan.push_back(mk(REQ_FREE, 32'h4000, '0));       // quotient equals entry count
    plan.push_back(mk(REQ_FREE, 32'h3FF0, '0));       // last block, in range
    plan.push_back(mk(REQ_XLATE, 32'hFFFF_FFFF, 10'h2AA));
    plan.push_back(mk(REQ_REINIT, 32'h0, '0));
    plan.push_back(mk(REQ_FREE, 32'h0, '0));
    plan.push_back(mk(REQ_ALLOC, 32'h0, '0));
    plan.push_back(mk(REQ_ALLOC, 32'h0, '0));
    // the random phase follows directly, so push is handed over, not dropped
    foreach (plan[i]) send_paced(plan[i], 1'b0);
    run_phase(150, 0);

    // Four one-byte blocks near the top of the space: exhaustion and
    // address wraparound.
    load_pool(1, 1, 4, 32'hFFFF_FFFE);
    plan.delete();
    plan.push_back(mk(REQ_REINIT, 32'h0, '0));
    repeat (5) plan.push_back(mk(REQ_ALLOC, 32'h0, '0));
    plan.push_back(mk(REQ_XLATE, 32'h0, 10'd4));      // out of range
    plan.push_back(mk(REQ_FREE, 32'h1, '0));          // offset wraps to block 3
    foreach (plan[i]) send_paced(plan[i], 1'b0);
    run_phase(150, 0);

    // largest raw size and power-of-two alignment, base at the very top
    load_pool(16'hFFFF, 4096, 1024, 32'hFFFF_FFFF);
    run_phase(150, 0);

    // empty pool, zero alignment, zero size
    load_pool(0, 0, 0, 32'h1234_5678);
    run_phase(40, 0);

    // zero block size with entries present: every free with blocks allocated is out of range
    load_pool(0, 16, 6, $urandom());
    run_phase(60, 0);

    // alignment not a power of two, entry count beyond the pool;
    // ends with extra allocations so the next, smaller pool starts over-full
    load_pool(100, 24, 2047, $urandom());
    run_phase(200, 6);
    load_pool(7, 8, 3, $urandom());
    run_phase(150, 0);

    // random geometries, mostly small pools so they fill up
    for (int p = 0; p < 5; p++) begin
      load_pool(($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 65535),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                            : (1 << $urandom_range(0, 12)),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 48),
                $urandom());
      run_phase(150, 0);
    end

    // drain, then give a free its full latency for any stray result
    settle(60);
    if (chk.errors == 0) begin
      $display("fixed_block_pool_allocator_unit test passed");
    end else begin
      $display("fixed_block_pool_allocator_unit test failed");
    end
    $finish;
  end

endmodule
